### rtl/ita_pkg.sv
package ita_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned BCD_W   = 4 * DIGITS;

    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] CHAR_ERROR    = 8'h00;
    localparam logic [7:0] NEED_SIGNED   = 8'd12;
    localparam logic [7:0] NEED_UNSIGNED = 8'd11;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_TRIM,
        CV_DONE
    } cv_state_t;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_ERR,
        EM_SIGN,
        EM_PAD,
        EM_DIGIT
    } em_state_t;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;   // digits, most significant nibble on top
        logic [3:0]       cnt;   // number of digits
        logic             neg;
        logic [4:0]       pad;
        logic [4:0]       total;
        logic             err;
    } job_t;

endpackage

### rtl/ita_conv.sv
module ita_conv #(
    parameter int MAX_PAD_WIDTH = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [31:0]   value_bits,
    input  logic          is_signed,
    input  logic [7:0]    dest_size,
    input  logic [4:0]    min_width,
    input  logic          zero_pad,
    output logic          job_valid,
    input  logic          job_ready,
    output ita_pkg::job_t job
);

    localparam int PadCap = (MAX_PAD_WIDTH < 31) ? MAX_PAD_WIDTH : 31;

    ita_pkg::cv_state_t state_reg, state_next;

    logic [ita_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [ita_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [4:0]                  step_reg, step_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic                        small_reg, small_next;
    logic [4:0]                  mw_reg, mw_next;
    logic                        zp_reg, zp_next;
    logic [7:0]                  ds_reg, ds_next;

    logic                        accept;
    logic                        neg_in;
    logic [7:0]                  need;
    logic [4:0]                  mw_clamped;
    logic [ita_pkg::BCD_W-1:0]   bcd_adj;
    logic [4:0]                  len;
    logic                        padding;

    assign in_ready = (state_reg == ita_pkg::CV_IDLE);
    assign accept   = in_valid && in_ready;
    assign neg_in   = is_signed && value_bits[31];
    assign need     = is_signed ? ita_pkg::NEED_SIGNED : ita_pkg::NEED_UNSIGNED;
    assign mw_clamped = (min_width > 5'(PadCap)) ? 5'(PadCap) : min_width;

    // add-3 correction on each BCD digit before the shift
    always_comb
    begin
        for (int d = 0; d < ita_pkg::DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ita_pkg::CV_IDLE:
                if (accept)
                    state_next = (dest_size < need) ? ita_pkg::CV_DONE : ita_pkg::CV_SHIFT;
            ita_pkg::CV_SHIFT:
                if (step_reg == 5'd31)
                    state_next = ita_pkg::CV_TRIM;
            ita_pkg::CV_TRIM:
                if (!(cnt_reg > 4'd1 && bcd_reg[ita_pkg::BCD_W-1 -: 4] == 4'd0))
                    state_next = ita_pkg::CV_DONE;
            ita_pkg::CV_DONE:
                if (job_ready)
                    state_next = ita_pkg::CV_IDLE;
            default:
                state_next = ita_pkg::CV_IDLE;
        endcase
    end

    always_comb
    begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        small_next = small_reg;
        mw_next    = mw_reg;
        zp_next    = zp_reg;
        ds_next    = ds_reg;
        unique case (state_reg)
            ita_pkg::CV_IDLE:
                if (accept)
                begin
                    bin_next   = neg_in ? (32'd0 - value_bits) : value_bits;
                    bcd_next   = '0;
                    step_next  = 5'd0;
                    cnt_next   = 4'(ita_pkg::DIGITS);
                    neg_next   = neg_in;
                    small_next = (dest_size < need);
                    mw_next    = mw_clamped;
                    zp_next    = zero_pad;
                    ds_next    = dest_size;
                end
            ita_pkg::CV_SHIFT:
            begin
                bcd_next  = {bcd_adj[ita_pkg::BCD_W-2:0], bin_reg[ita_pkg::VALUE_W-1]};
                bin_next  = {bin_reg[ita_pkg::VALUE_W-2:0], 1'b0};
                step_next = step_reg + 5'd1;
            end
            ita_pkg::CV_TRIM:
                if (cnt_reg > 4'd1 && bcd_reg[ita_pkg::BCD_W-1 -: 4] == 4'd0)
                begin
                    bcd_next = {bcd_reg[ita_pkg::BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - 4'd1;
                end
            ita_pkg::CV_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign len     = {1'b0, cnt_reg} + {4'd0, neg_reg};
    assign padding = zp_reg && (len < mw_reg);

    assign job_valid = (state_reg == ita_pkg::CV_DONE);
    assign job.bcd   = bcd_reg;
    assign job.cnt   = cnt_reg;
    assign job.neg   = neg_reg;
    assign job.pad   = padding ? (mw_reg - len) : 5'd0;
    assign job.total = padding ? mw_reg : len;
    assign job.err   = small_reg || (padding && ({3'd0, mw_reg} >= ds_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ita_pkg::CV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        step_reg  <= step_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        small_reg <= small_next;
        mw_reg    <= mw_next;
        zp_reg    <= zp_next;
        ds_reg    <= ds_next;
    end

endmodule

### rtl/ita_emit.sv
module ita_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  ita_pkg::job_t job,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);

    ita_pkg::em_state_t state_reg, state_next;

    logic [ita_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic [4:0]                pad_reg, pad_next;
    logic [4:0]                total_reg, total_next;

    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic [4:0] len_reg, len_next;
    logic       err_reg, err_next;

    logic       take;
    logic       fire;
    logic [3:0] top_digit;

    assign job_ready = (state_reg == ita_pkg::EM_IDLE);
    assign take      = job_valid && job_ready;
    assign fire      = (state_reg != ita_pkg::EM_IDLE) && (!valid_reg || m_tready);
    assign top_digit = bcd_reg[ita_pkg::BCD_W-1 -: 4];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ita_pkg::EM_IDLE:
                if (take)
                begin
                    if (job.err)
                        state_next = ita_pkg::EM_ERR;
                    else if (job.neg)
                        state_next = ita_pkg::EM_SIGN;
                    else if (job.pad != 5'd0)
                        state_next = ita_pkg::EM_PAD;
                    else
                        state_next = ita_pkg::EM_DIGIT;
                end
            ita_pkg::EM_ERR:
                if (fire)
                    state_next = ita_pkg::EM_IDLE;
            ita_pkg::EM_SIGN:
                if (fire)
                    state_next = (pad_reg != 5'd0) ? ita_pkg::EM_PAD : ita_pkg::EM_DIGIT;
            ita_pkg::EM_PAD:
                if (fire && pad_reg == 5'd1)
                    state_next = ita_pkg::EM_DIGIT;
            ita_pkg::EM_DIGIT:
                if (fire && cnt_reg == 4'd1)
                    state_next = ita_pkg::EM_IDLE;
            default:
                state_next = ita_pkg::EM_IDLE;
        endcase
    end

    always_comb
    begin
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        total_next = total_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        valid_next = valid_reg && !m_tready;
        if (fire)
        begin
            valid_next = 1'b1;
            last_next  = 1'b0;
            len_next   = 5'd0;
            err_next   = 1'b0;
        end
        unique case (state_reg)
            ita_pkg::EM_IDLE:
                if (take)
                begin
                    bcd_next   = job.bcd;
                    cnt_next   = job.cnt;
                    pad_next   = job.pad;
                    total_next = job.total;
                end
            ita_pkg::EM_ERR:
                if (fire)
                begin
                    char_next = ita_pkg::CHAR_ERROR;
                    last_next = 1'b1;
                    err_next  = 1'b1;
                end
            ita_pkg::EM_SIGN:
                if (fire)
                    char_next = ita_pkg::CHAR_MINUS;
            ita_pkg::EM_PAD:
                if (fire)
                begin
                    char_next = ita_pkg::CHAR_ZERO;
                    pad_next  = pad_reg - 5'd1;
                end
            ita_pkg::EM_DIGIT:
                if (fire)
                begin
                    char_next = ita_pkg::CHAR_ZERO + {4'd0, top_digit};
                    bcd_next  = {bcd_reg[ita_pkg::BCD_W-5:0], 4'd0};
                    cnt_next  = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        last_next = 1'b1;
                        len_next  = total_reg;
                    end
                end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, len_reg, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ita_pkg::EM_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        pad_reg   <= pad_next;
        total_reg <= total_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        len_reg   <= len_next;
        err_reg   <= err_next;
    end

endmodule

### rtl/integer_to_decimal_ascii.sv
// Converts a 32-bit value, signed or unsigned, to decimal ASCII, one character
// per output word with tlast on the final one and the text length beside it.
// A converter shifts the value one bit per cycle through a ten-digit BCD register,
// then drops leading zero digits one per cycle and hands the digits to an emitter.
// The emitter writes one character per cycle unless the receiver stalls (sign,
// pad zeros, digits), at most 31 per item, while the converter already works on
// the next item. A destination too small for the widest text yields a single
// error word (tuser set, character and length zero) without waiting for the
// conversion; one too small for the padded text yields the same word after it.
module integer_to_decimal_ascii #(
    parameter int MAX_PAD_WIDTH = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // value_bits[31:0], is_signed[32], dest_size[40:33], min_width[45:41],
    // zero_pad[46], zero[47]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // character[7:0], text_length[12:8], zero[15:13]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // error[0]
    output logic        m_tuser
);

    logic          job_valid;
    logic          job_ready;
    ita_pkg::job_t job;

    ita_conv #(
        .MAX_PAD_WIDTH(MAX_PAD_WIDTH)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .value_bits(s_tdata[31:0]),
        .is_signed (s_tdata[32]),
        .dest_size (s_tdata[40:33]),
        .min_width (s_tdata[45:41]),
        .zero_pad  (s_tdata[46]),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    ita_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .job      (job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/ita_checker.sv
module ita_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // error word stands alone
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[12:0] == 13'd0)
    else $error("error word malformed");

    // length only on the last word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[12:8] == 5'd0)
    else $error("length on non-last word");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            (m_tdata[7:0] >= ita_pkg::CHAR_ZERO && m_tdata[7:0] <= 8'h39) ||
            m_tdata[7:0] == ita_pkg::CHAR_MINUS)
    else $error("character not a digit or minus");

    // a text that ends in a digit never has zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata[12:8] != 5'd0)
    else $error("last word without length");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled word changed");

endmodule

bind integer_to_decimal_ascii ita_checker u_ita_checker (.*);

### tb/tb_top.sv
module tb_top;

    localparam int          MAX_PAD_WIDTH = 31;
    localparam int          RANDOM_ITEMS  = 300;
    localparam int unsigned HANG_LIMIT    = 4000;
    localparam int          TAIL_CYCLES   = 120;

    typedef struct {
        logic [31:0] value_bits;
        logic        is_signed;
        logic [7:0]  dest_size;
        logic [4:0]  min_width;
        logic        zero_pad;
        bit          drain_first;   // hold off until all text is out
    } conv_req_t;

    typedef struct {
        logic [7:0] character;
        logic       last;
        logic [4:0] text_length;
        logic       error;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    conv_req_t    pending_reqs[$];
    text_char_t   expected_text[$];
    conv_req_t    req_on_bus;
    int unsigned  send_gap;
    int unsigned  recv_stall;
    int unsigned  reqs_sent;
    int unsigned  cycle_no;
    int unsigned  idle_cycles;
    int unsigned  mismatches = 0;

    integer_to_decimal_ascii #(
        .MAX_PAD_WIDTH(MAX_PAD_WIDTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void push_char(input logic [7:0] ch, input logic lst,
                                      input logic [4:0] len, input logic err);
        text_char_t w;
        w.character   = ch;
        w.last        = lst;
        w.text_length = len;
        w.error       = err;
        expected_text.push_back(w);
    endfunction

    // decimal text of one request: sign, pad zeros, digits msd first, or a lone error word
    function automatic void predict_text(input conv_req_t r);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] rest;
        logic [3:0]  digits[10];
        int unsigned need;
        int unsigned cnt;
        int unsigned len;
        int unsigned width;
        int unsigned pad;
        int unsigned total;
        int unsigned emitted;
        neg  = r.is_signed & r.value_bits[31];
        mag  = neg ? (32'd0 - r.value_bits) : r.value_bits;
        need = r.is_signed ? 32'(ita_pkg::NEED_SIGNED) : 32'(ita_pkg::NEED_UNSIGNED);
        if (32'(r.dest_size) < need)
        begin
            push_char(ita_pkg::CHAR_ERROR, 1'b1, 5'd0, 1'b1);
            return;
        end
        cnt  = 0;
        rest = mag;
        do
        begin
            digits[cnt] = 4'(rest % 10);
            rest        = rest / 10;
            cnt++;
        end
        while (rest != 0 && cnt < 10);
        len   = cnt + 32'(neg);
        width = (32'(r.min_width) > MAX_PAD_WIDTH) ? MAX_PAD_WIDTH : 32'(r.min_width);
        pad   = 0;
        if (r.zero_pad && len < width)
        begin
            pad = width - len;
            if (len + pad >= 32'(r.dest_size))
            begin
                push_char(ita_pkg::CHAR_ERROR, 1'b1, 5'd0, 1'b1);
                return;
            end
        end
        total   = len + pad;
        emitted = 0;
        if (neg)
        begin
            emitted++;
            push_char(ita_pkg::CHAR_MINUS, emitted == total,
                      (emitted == total) ? 5'(total) : 5'd0, 1'b0);
        end
        for (int i = 0; i < pad; i++)
        begin
            emitted++;
            push_char(ita_pkg::CHAR_ZERO, emitted == total,
                      (emitted == total) ? 5'(total) : 5'd0, 1'b0);
        end
        for (int i = cnt; i > 0; i--)
        begin
            emitted++;
            push_char(ita_pkg::CHAR_ZERO + {4'd0, digits[i-1]}, emitted == total,
                      (emitted == total) ? 5'(total) : 5'd0, 1'b0);
        end
    endfunction

    task automatic add_req(input logic [31:0] v, input logic sg, input logic [7:0] ds,
                           input logic [4:0] mw, input logic zp, input bit drain);
        conv_req_t r;
        r.value_bits  = v;
        r.is_signed   = sg;
        r.dest_size   = ds;
        r.min_width   = mw;
        r.zero_pad    = zp;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_gap  <= 0;
            reqs_sent <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_text(req_on_bus);
            if (s_tvalid && !s_tready)
            begin
                s_tvalid <= 1'b1;
            end
            else if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() != 0 &&
                     (!pending_reqs[0].drain_first || expected_text.size() == 0))
            begin
                req_on_bus = pending_reqs.pop_front();
                s_tdata  <= {1'b0, req_on_bus.zero_pad, req_on_bus.min_width,
                             req_on_bus.dest_size, req_on_bus.is_signed,
                             req_on_bus.value_bits};
                s_tvalid <= 1'b1;
                send_gap <= ((reqs_sent % 64) < 12) ? 0 : idle_len();
                reqs_sent <= reqs_sent + 1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // character monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
            cycle_no   <= 0;
        end
        else
        begin
            cycle_no <= cycle_no + 1;
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected word: character expected none actual %0h",
                           m_tdata[7:0]);
                    mismatches++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata[7:0] !== want.character)
                    begin
                        $error("character: expected %0h actual %0h",
                               want.character, m_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b actual %0b", want.last, m_tlast);
                        mismatches++;
                    end
                    if (m_tdata[12:8] !== want.text_length)
                    begin
                        $error("text_length: expected %0d actual %0d",
                               want.text_length, m_tdata[12:8]);
                        mismatches++;
                    end
                    if (m_tuser !== want.error)
                    begin
                        $error("error: expected %0b actual %0b", want.error, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (recv_stall != 0)
            begin
                m_tready   <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                m_tready   <= 1'b1;
                recv_stall <= ((cycle_no % 2048) < 400) ? 0 : idle_len();
            end
        end
    end

    // cycles with no word moving on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned r;
        logic [31:0] v;
        logic [7:0]  ds;

        // extremes and corner cases
        add_req(32'd0,          1'b0, 8'd11,  5'd0,  1'b0, 0);
        add_req(32'hFFFF_FFFF,  1'b0, 8'd255, 5'd0,  1'b0, 0);
        add_req(32'h8000_0000,  1'b1, 8'd12,  5'd0,  1'b0, 0);
        add_req(32'h7FFF_FFFF,  1'b1, 8'd12,  5'd31, 1'b0, 0);
        add_req(32'hFFFF_FFFF,  1'b1, 8'd12,  5'd0,  1'b0, 0);
        add_req(32'd0,          1'b1, 8'd12,  5'd0,  1'b0, 0);
        add_req(32'd12345,      1'b1, 8'd11,  5'd0,  1'b0, 0);
        add_req(32'd12345,      1'b0, 8'd10,  5'd0,  1'b0, 0);
        add_req(32'hFFFF_FFFF,  1'b1, 8'd0,   5'd31, 1'b1, 0);
        add_req(32'd5,          1'b0, 8'd20,  5'd8,  1'b1, 0);
        add_req(-32'sd42,       1'b1, 8'd12,  5'd6,  1'b1, 0);
        add_req(32'd7,          1'b0, 8'd12,  5'd12, 1'b1, 0);
        add_req(32'd7,          1'b0, 8'd12,  5'd11, 1'b1, 0);
        add_req(32'd0,          1'b0, 8'd255, 5'd31, 1'b1, 1);
        add_req(32'h8000_0000,  1'b1, 8'd32,  5'd31, 1'b1, 0);
        add_req(32'h8000_0000,  1'b1, 8'd31,  5'd31, 1'b1, 0);
        add_req(32'd99,         1'b0, 8'd128, 5'd31, 1'b0, 0);
        add_req(32'd123456,     1'b0, 8'd11,  5'd3,  1'b1, 0);
        add_req(32'd1000000000, 1'b0, 8'd11,  5'd10, 1'b1, 0);
        add_req(32'd4000000000, 1'b1, 8'd200, 5'd15, 1'b1, 1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                v = $urandom;
            else if (r < 60)
                v = $urandom_range(0, 99);
            else if (r < 80)
                v = $urandom >> $urandom_range(0, 31);
            else if (r < 90)
                v = 32'h8000_0000 + $urandom_range(0, 3) - 2;
            else
                v = 32'hFFFF_FFFF - $urandom_range(0, 3);
            r = $urandom_range(0, 99);
            if (r < 70)
                ds = 8'($urandom_range(11, 40));
            else if (r < 85)
                ds = 8'($urandom_range(0, 12));
            else
                ds = 8'($urandom_range(0, 255));
            add_req(v, 1'($urandom_range(0, 1)), ds, 5'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1)), (i % 50) == 25);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(pending_reqs.size() == 0 && !s_tvalid && expected_text.size() == 0) &&
               idle_cycles < HANG_LIMIT)
            @(posedge clk);

        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (mismatches == 0 && expected_text.size() == 0)
                $display("SCOREBOARD CLEAN");
            else
                $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
rtl/ita_pkg.sv
rtl/ita_conv.sv
rtl/ita_emit.sv
rtl/integer_to_decimal_ascii.sv
rtl/ita_checker.sv
tb/tb_top.sv
